### hw/rtl/lsd_pkg.sv
// Shared constants, types and record layouts for the loop stream detector.
package lsd_pkg;

  localparam int HISTORY_DEPTH = 32;
  localparam int IDX_W = $clog2(HISTORY_DEPTH);
  localparam int FILL_W = $clog2(HISTORY_DEPTH + 1);
  localparam int PC_W = 48;
  localparam int MICRO_W = 8;
  localparam int ADDR_W = PC_W + MICRO_W;
  localparam int DIST_W = 8;
  localparam int REP_W = 16;
  localparam int ITER_W = 16;
  localparam int CFG_W = 4;

  localparam logic [REP_W-1:0] REP_MAX = '1;
  localparam logic [ITER_W-1:0] ITER_MAX = '1;
  localparam logic [CFG_W-1:0] FIRST_ITER_RESET = CFG_W'(1);

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [DIST_W-1:0] dist_t;
  typedef logic [REP_W-1:0] rep_t;
  typedef logic [HISTORY_DEPTH-1:0] vec_t;

  typedef struct packed {
    addr_t addr;
    dist_t distance;
    rep_t  rep;
    logic  head;
  } entry_t;

  typedef struct packed {
    logic hit;
    logic same;
    logic eqd;
  } cmp_t;

  typedef struct packed {
    logic  found;
    logic  near;
    logic  eq_dist;
    logic  potential;
    dist_t new_dist;
    rep_t  new_count;
    addr_t head_addr;
  } search_t;

  typedef struct packed {
    logic [PC_W-1:0]    fetch_pc;
    logic [MICRO_W-1:0] fetch_micro_index;
  } fetch_t;

  typedef struct packed {
    logic               in_loop;
    logic               loop_head;
    logic               first_pass;
    logic [ITER_W-1:0]  iteration_number;
    logic [PC_W-1:0]    loop_start_pc;
    logic [MICRO_W-1:0] loop_start_micro;
    logic [PC_W-1:0]    loop_end_pc;
    logic [MICRO_W-1:0] loop_end_micro;
  } result_t;

endpackage

### hw/rtl/lsd_cell.sv
// One history cell: a stored entry that shifts to its neighbor and compares itself.
module lsd_cell (
  input  logic           clk,
  input  logic           shift_en,
  input  lsd_pkg::entry_t entry_in,
  input  lsd_pkg::addr_t probe,
  input  lsd_pkg::dist_t d0,
  input  lsd_pkg::rep_t  c0,
  input  lsd_pkg::dist_t pos_dist,
  input  logic           valid,
  output lsd_pkg::entry_t entry,
  output lsd_pkg::cmp_t  flags
);
  import lsd_pkg::*;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      entry <= entry_in;
    end
  end

  always_comb begin
    flags.hit  = valid && (entry.addr == probe);
    flags.same = (entry.distance == d0) && (entry.rep == c0);
    flags.eqd  = (entry.distance == pos_dist);
  end

endmodule

### hw/rtl/lsd_chain.sv
// Row of history cells with fill count, registered compare flags and first-match search.
module lsd_chain (
  input  logic             clk,
  input  logic             rst,
  input  logic             probe_en,
  input  lsd_pkg::addr_t   probe,
  input  logic             ins_en,
  input  lsd_pkg::entry_t  ins,
  output lsd_pkg::search_t search,
  output logic             empty
);
  import lsd_pkg::*;

  entry_t cell_entry [HISTORY_DEPTH];
  cmp_t   cell_flags [HISTORY_DEPTH];
  logic [FILL_W-1:0] fill;
  logic [FILL_W-1:0] fill_next;
  vec_t hit_q;
  vec_t same_q;
  vec_t eqd_q;
  logic nz0_q;
  vec_t first;
  vec_t upto;
  logic [IDX_W-1:0] idx;
  rep_t rep_sel;

  for (genvar i = 0; i < HISTORY_DEPTH; i++) begin : g_cell
    lsd_cell u_cell (
      .clk      (clk),
      .shift_en (ins_en),
      .entry_in ((i == 0) ? ins : cell_entry[(i == 0) ? 0 : i - 1]),
      .probe    (probe),
      .d0       (cell_entry[0].distance),
      .c0       (cell_entry[0].rep),
      .pos_dist (DIST_W'(i + 1)),
      .valid    (FILL_W'(i) < fill),
      .entry    (cell_entry[i]),
      .flags    (cell_flags[i])
    );
  end

  always_comb begin
    fill_next = fill;
    if (ins_en && (fill != FILL_W'(HISTORY_DEPTH))) begin
      fill_next = fill + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else begin
      fill <= fill_next;
    end
  end

  always_ff @(posedge clk) begin
    if (probe_en) begin
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
        hit_q[i]  <= cell_flags[i].hit;
        same_q[i] <= cell_flags[i].same;
        eqd_q[i]  <= cell_flags[i].eqd;
      end
      nz0_q <= (cell_entry[0].distance != '0);
    end
  end

  always_comb begin
    first = hit_q & (~hit_q + 1'b1);
    upto  = first | (first - 1'b1);
    idx = '0;
    rep_sel = '0;
    for (int i = 0; i < HISTORY_DEPTH; i++) begin
      if (first[i]) begin
        idx = idx | IDX_W'(i);
        rep_sel = rep_sel | cell_entry[i].rep;
      end
    end
    search.found     = |hit_q;
    search.near      = first[0];
    search.eq_dist   = |(first & eqd_q);
    search.potential = nz0_q && ((~same_q & upto) == '0);
    search.new_dist  = DIST_W'(idx) + 1'b1;
    search.new_count = (rep_sel == REP_MAX) ? rep_sel : rep_sel + 1'b1;
    search.head_addr = cell_entry[0].addr;
  end

  assign empty = (fill == '0);

endmodule

### hw/rtl/loop_stream_detector.sv
// Top level of the loop stream detector: compare stage, loop tracking and result register.
//
//  channel  | valid         | ready         | payload
//  ---------+---------------+---------------+---------------------------
//  fetch    | fetch_valid   | fetch_ready   | fetch  (lsd_pkg::fetch_t)
//  result   | result_valid  | result_ready  | result (lsd_pkg::result_t)
//  config   | config_we     | (none)        | config_data
//
// Each fetch transfer has a compare step, which checks the address against every history
// cell at once, then a resolve step that finds the nearest match and updates the loop state.
// The result register lets the next fetch be taken while a result waits.
// Reset clears the fill count, the loop state and the handshakes; a stalled result
// holds the resolve step back until the result register frees up.
module loop_stream_detector (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 fetch_valid,
  output logic                 fetch_ready,
  input  lsd_pkg::fetch_t      fetch,
  output logic                 result_valid,
  input  logic                 result_ready,
  output lsd_pkg::result_t     result,
  input  logic                 config_we,
  input  logic [lsd_pkg::CFG_W-1:0] config_data
);
  import lsd_pkg::*;

  logic [CFG_W-1:0] first_iter;
  logic s1_valid;
  addr_t a_in;
  addr_t a_q;
  logic contains_q;
  logic a_le_h0_q;
  logic fire;
  logic accept;
  search_t search;
  logic empty;
  entry_t ins;

  logic loop_is_active;
  logic loop_is_active_next;
  addr_t loop_start;
  addr_t loop_start_next;
  addr_t loop_end;
  addr_t loop_end_next;
  logic [ITER_W-1:0] loop_iteration;
  logic [ITER_W-1:0] loop_iteration_next;
  result_t result_next;

  logic repeat_hit;
  logic started;
  logic act;

  assign a_in = {fetch.fetch_pc, fetch.fetch_micro_index};
  assign fetch_ready = !s1_valid;
  assign accept = fetch_valid && fetch_ready;
  assign fire = s1_valid && (!result_valid || result_ready);

  lsd_chain u_chain (
    .clk      (clk),
    .rst      (rst),
    .probe_en (accept),
    .probe    (a_in),
    .ins_en   (fire),
    .ins      (ins),
    .search   (search),
    .empty    (empty)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      first_iter <= FIRST_ITER_RESET;
    end else if (config_we) begin
      first_iter <= config_data;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_q        <= a_in;
      contains_q <= (loop_start <= a_in) && (a_in <= loop_end);
      a_le_h0_q  <= (a_in <= search.head_addr);
    end
  end

  always_comb begin
    repeat_hit = !empty && search.found && !search.near;
    ins.addr = a_q;
    ins.distance = repeat_hit ? search.new_dist : '0;
    ins.rep  = (repeat_hit && search.eq_dist) ? search.new_count : '0;
    ins.head = repeat_hit && search.eq_dist && search.potential;

    loop_is_active_next = loop_is_active;
    loop_start_next     = loop_start;
    loop_end_next       = loop_end;
    loop_iteration_next = loop_iteration;
    started = 1'b0;
    if (!empty) begin
      if (!(repeat_hit && search.eq_dist)) begin
        loop_is_active_next = 1'b0;
      end else if (search.potential) begin
        if (loop_is_active && contains_q) begin
          if (loop_iteration != ITER_MAX) begin
            loop_iteration_next = loop_iteration + 1'b1;
          end
        end else begin
          started = 1'b1;
          loop_start_next     = a_q;
          loop_end_next       = search.head_addr;
          loop_iteration_next = ITER_W'(first_iter);
          loop_is_active_next = 1'b1;
        end
      end
    end

    act = loop_is_active_next && (started ? a_le_h0_q : contains_q);
    result_next.in_loop          = act;
    result_next.loop_head        = ins.head;
    result_next.first_pass       = act && (loop_iteration_next == ITER_W'(first_iter));
    result_next.iteration_number = act ? loop_iteration_next : '0;
    result_next.loop_start_pc    = act ? loop_start_next[ADDR_W-1:MICRO_W] : '0;
    result_next.loop_start_micro = act ? loop_start_next[MICRO_W-1:0] : '0;
    result_next.loop_end_pc      = act ? loop_end_next[ADDR_W-1:MICRO_W] : '0;
    result_next.loop_end_micro   = act ? loop_end_next[MICRO_W-1:0] : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid       <= 1'b0;
      result_valid   <= 1'b0;
      loop_is_active <= 1'b0;
      loop_start     <= '0;
      loop_end       <= '0;
      loop_iteration <= '0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (fire) begin
        s1_valid <= 1'b0;
      end
      if (fire) begin
        result_valid   <= 1'b1;
        loop_is_active <= loop_is_active_next;
        loop_start     <= loop_start_next;
        loop_end       <= loop_end_next;
        loop_iteration <= loop_iteration_next;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      result <= result_next;
    end
  end

`ifndef ASSERT_OFF
  a_busy_after_transfer : assert property (@(posedge clk) disable iff (rst)
    (fetch_valid && fetch_ready) |=> !fetch_ready)
    else $error("fetch accepted while the compare stage was occupied");

  a_first_pass_in_loop : assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.first_pass) |-> result.in_loop)
    else $error("first pass flagged outside a loop");

  a_zero_outside_loop : assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result.in_loop) |->
      (result.iteration_number == '0) && (result.loop_start_pc == '0) &&
      (result.loop_end_pc == '0))
    else $error("loop fields not cleared outside a loop");
`endif

endmodule
